/* sv/fpss_pkg.sv */
// Shared constants, register indexes and types of the five-point stencil smoother.
package fpss_pkg;

  // Default configuration of the datapath.
  localparam int unsigned MAX_WIDTH_DEF   = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register field widths, fixed by the register map.
  localparam int unsigned GRID_W_BITS = 11;
  localparam int unsigned ROW_BITS    = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Reset values of the registers.
  localparam logic [GRID_W_BITS-1:0] GRID_WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_BITS-1:0]    GRID_HEIGHT_RESET = 16'd1024;

  // Smallest grid dimension that the raster counters honour.
  localparam int unsigned MIN_DIM = 3;

  // Position flags of one sample, carried with it down the pipeline.
  typedef struct packed {
    logic produce;  // sample completes an interior point
    logic last;     // that point is the final interior point of the grid
  } fpss_flags_t;

endpackage

/* sv/fpss_line_store.sv */
// One row of past samples held in a simple dual-port RAM with registered read data.
module fpss_line_store import fpss_pkg::*; #(
  parameter int unsigned DATA_W = SAMPLE_BITS_DEF,
  parameter int unsigned DEPTH  = MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fpss_raster.sv */
// Configuration registers and raster column and row counters.
module fpss_raster import fpss_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         step_i,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col_o,
  output logic [ROW_BITS-1:0]          out_row_o,
  output fpss_flags_t                  flags_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  logic [GRID_W_BITS-1:0] grid_width_q, grid_width_d;
  logic [ROW_BITS-1:0]    grid_height_q, grid_height_d;
  logic [ColW-1:0]        col_q, col_d;
  logic [ROW_BITS-1:0]    row_q, row_d;

  logic [ColW:0]          eff_w;
  logic [ROW_BITS-1:0]    eff_h;
  logic [ColW:0]          col_next;
  logic [ROW_BITS:0]      row_next;
  logic                   col_end;
  logic                   row_end;
  logic                   wr_width;
  logic                   wr_height;

  assign wr_width  = cfg_valid_i && (cfg_index_i == REG_GRID_WIDTH);
  assign wr_height = cfg_valid_i && (cfg_index_i == REG_GRID_HEIGHT);

  // Width clamped to the range that the line stores can hold.
  always_comb begin
    if (grid_width_q < GRID_W_BITS'(MIN_DIM)) begin
      eff_w = (ColW+1)'(MIN_DIM);
    end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = (ColW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (ColW+1)'(grid_width_q);
    end
  end

  // Height clamped from below only.
  assign eff_h = (grid_height_q < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : grid_height_q;

  // End of row and end of grid detection.
  assign col_next = {1'b0, col_q} + (ColW+1)'(1);
  assign row_next = {1'b0, row_q} + (ROW_BITS+1)'(1);
  assign col_end  = col_next >= eff_w;
  assign row_end  = row_next >= {1'b0, eff_h};

  // A write to either register restarts the grid at its first sample.
  always_comb begin
    grid_width_d  = grid_width_q;
    grid_height_d = grid_height_q;
    col_d         = col_q;
    row_d         = row_q;
    if (wr_width || wr_height) begin
      if (wr_width) begin
        grid_width_d = cfg_data_i[GRID_W_BITS-1:0];
      end
      if (wr_height) begin
        grid_height_d = cfg_data_i[ROW_BITS-1:0];
      end
      col_d = '0;
      row_d = '0;
    end else if (step_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_next[ROW_BITS-1:0];
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RESET;
      grid_height_q <= GRID_HEIGHT_RESET;
      col_q         <= '0;
      row_q         <= '0;
    end else begin
      grid_width_q  <= grid_width_d;
      grid_height_q <= grid_height_d;
      col_q         <= col_d;
      row_q         <= row_d;
    end
  end

  // The sample at (row, col) completes the point one row up and one column left.
  assign col_o           = col_q;
  assign out_col_o       = col_q - ColW'(1);
  assign out_row_o       = row_q - ROW_BITS'(1);
  assign flags_o.produce = (row_q >= ROW_BITS'(2)) && (col_q >= ColW'(2));
  assign flags_o.last    = col_end && row_end;

endmodule

/* sv/fpss_stencil.sv */
// Centre-row window, neighbour delays, stencil adder and result register.
module fpss_stencil import fpss_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned COL_W       = $clog2(MAX_WIDTH_DEF)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [SAMPLE_BITS-1:0] old_above_i,
  input  logic signed [SAMPLE_BITS-1:0] new_above_i,
  input  fpss_flags_t                 flags_i,
  input  logic [COL_W-1:0]            col_i,
  input  logic [ROW_BITS-1:0]         row_i,
  output logic                        advance_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_BITS+2:0] smoothed_o,
  output logic [COL_W-1:0]            out_col_o,
  output logic [ROW_BITS-1:0]         out_row_o,
  output logic                        last_o
);

  localparam int unsigned OutW = SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] win1_q, win2_q;
  logic signed [SAMPLE_BITS-1:0] north_q, south_q;
  logic signed [OutW-1:0]        sum;
  logic                          out_valid_q;
  logic signed [OutW-1:0]        smoothed_q;
  logic [COL_W-1:0]              out_col_q;
  logic [ROW_BITS-1:0]           out_row_q;
  logic                          last_q;

  // The result register can take a new beat when empty or being drained.
  assign advance_o = !out_valid_q || out_ready_i;

  // Four times the centre plus west, east, north and south.
  assign sum = (OutW'(win2_q) <<< 2) + OutW'(win1_q) + OutW'(new_above_i)
             + OutW'(north_q) + OutW'(south_q);

  // Window and neighbour delays move on every processed sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q  <= '0;
      win2_q  <= '0;
      north_q <= '0;
      south_q <= '0;
    end else if (fire_i) begin
      win1_q  <= win2_q;
      win2_q  <= new_above_i;
      north_q <= old_above_i;
      south_q <= sample_i;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      out_valid_q <= fire_i && flags_i.produce;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire_i && flags_i.produce) begin
      smoothed_q <= sum;
      out_col_q  <= col_i;
      out_row_q  <= row_i;
      last_q     <= flags_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign out_col_o   = out_col_q;
  assign out_row_o   = out_row_q;
  assign last_o      = last_q;

endmodule

/* sv/five_point_stencil_smoother.sv */
// Top level of the streaming five-point stencil smoother.
// Takes one signed sample per clock in raster order while results are drained and, for
// every interior point of a grid_width by grid_height grid, returns 4*centre + north +
// south + west + east, which is half the centre plus an eighth of each neighbour in
// units of one eighth of a sample step, exact and never saturated. The point at row
// r-1, column c-1 is computed once the sample at row r, column c has passed the input
// register stage and is then held in the result register until it is taken; boundary
// points give no beat. A new sample is taken every clock while results are drained, so
// the sustained rate is one sample per cycle, set by the single read port of each line
// store that is read once per sample. Registers: index 0 is grid_width (clamped to
// 3..MAX_WIDTH), index 1 is grid_height (at least 3); any write to them restarts the
// grid at row 0, column 0 and must be made while the block is idle. last_o marks the
// final interior point of each grid, after which the next grid follows directly.
module five_point_stencil_smoother import fpss_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SAMPLE_BITS+2:0] smoothed_o,
  output logic [$clog2(MAX_WIDTH)-1:0] out_col_o,
  output logic [ROW_BITS-1:0]          out_row_o,
  output logic                         last_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);

  logic                          in_accept;
  logic                          advance;
  logic                          s1_fire;
  logic [ColW-1:0]               rd_col;
  logic [ColW-1:0]               pt_col;
  logic [ROW_BITS-1:0]           pt_row;
  fpss_flags_t                   pt_flags;
  logic signed [SAMPLE_BITS-1:0] old_above;
  logic signed [SAMPLE_BITS-1:0] new_above;

  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic [ColW-1:0]               s1_col_q;
  logic [ColW-1:0]               s1_pt_col_q;
  logic [ROW_BITS-1:0]           s1_pt_row_q;
  fpss_flags_t                   s1_flags_q;

  // Handshake: the input stage frees up whenever its beat moves on.
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign s1_fire     = s1_valid_q && advance;

  fpss_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (in_accept),
    .col_o       (rd_col),
    .out_col_o   (pt_col),
    .out_row_o   (pt_row),
    .flags_o     (pt_flags)
  );

  // Input register stage, alongside the line store reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= sample_i;
      s1_col_q    <= rd_col;
      s1_pt_col_q <= pt_col;
      s1_pt_row_q <= pt_row;
      s1_flags_q  <= pt_flags;
    end
  end

  // Row two above the incoming sample.
  fpss_line_store #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (MAX_WIDTH)
  ) u_older_row (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (new_above),
    .re_i    (in_accept),
    .raddr_i (rd_col),
    .rdata_o (old_above)
  );

  // Row directly above the incoming sample.
  fpss_line_store #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (MAX_WIDTH)
  ) u_newer_row (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_col_q),
    .wdata_i (s1_sample_q),
    .re_i    (in_accept),
    .raddr_i (rd_col),
    .rdata_o (new_above)
  );

  fpss_stencil #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       (ColW)
  ) u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .sample_i    (s1_sample_q),
    .old_above_i (old_above),
    .new_above_i (new_above),
    .flags_i     (s1_flags_q),
    .col_i       (s1_pt_col_q),
    .row_i       (s1_pt_row_q),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smoothed_o  (smoothed_o),
    .out_col_o   (out_col_o),
    .out_row_o   (out_row_o),
    .last_o      (last_o)
  );

endmodule
